// ----- src/ptap_pkg.sv -----
// Shared constants for the point transform about pivot block.
package ptap_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int COEF_WIDTH_DEFAULT  = 16;

   localparam int SLOT_BITS      = 16;
   localparam int ROW_WIDTH      = 3 * SLOT_BITS;
   localparam int COEF_FRAC      = 12;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = ROW_WIDTH;

   typedef logic [CSR_ADDR_WIDTH-1:0] csr_addr_type;
   typedef logic [ROW_WIDTH-1:0]      row_type;

   localparam csr_addr_type CSR_ROW_TOP    = 3'd0;
   localparam csr_addr_type CSR_ROW_MIDDLE = 3'd1;
   localparam csr_addr_type CSR_ROW_BOTTOM = 3'd2;
   localparam csr_addr_type CSR_PIVOT_X    = 3'd3;
   localparam csr_addr_type CSR_PIVOT_Y    = 3'd4;
   localparam csr_addr_type CSR_PIVOT_Z    = 3'd5;

   localparam row_type ROW_TOP_RESET    = 48'h1000_0000_0000;
   localparam row_type ROW_MIDDLE_RESET = 48'h0000_1000_0000;
   localparam row_type ROW_BOTTOM_RESET = 48'h0000_0000_1000;

endpackage

// ----- src/ptap_csr.sv -----
// Configuration registers: matrix rows and pivot coordinates.
module ptap_csr #(
   parameter int COORD_WIDTH = ptap_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  ptap_pkg::csr_addr_type               csr_addr,
   input  logic [ptap_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output logic [2:0][ptap_pkg::ROW_WIDTH-1:0]  rows,
   output logic [2:0][COORD_WIDTH-1:0]          pivots
);

   ptap_pkg::row_type          row_ff   [3];
   ptap_pkg::row_type          row_in   [3];
   logic [COORD_WIDTH-1:0]     pivot_ff [3];
   logic [COORD_WIDTH-1:0]     pivot_in [3];

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         row_in[i]   = row_ff[i];
         pivot_in[i] = pivot_ff[i];
      end
      if (csr_valid) begin
         unique case (csr_addr)
            ptap_pkg::CSR_ROW_TOP:    row_in[0]   = csr_wdata[ptap_pkg::ROW_WIDTH-1:0];
            ptap_pkg::CSR_ROW_MIDDLE: row_in[1]   = csr_wdata[ptap_pkg::ROW_WIDTH-1:0];
            ptap_pkg::CSR_ROW_BOTTOM: row_in[2]   = csr_wdata[ptap_pkg::ROW_WIDTH-1:0];
            ptap_pkg::CSR_PIVOT_X:    pivot_in[0] = csr_wdata[COORD_WIDTH-1:0];
            ptap_pkg::CSR_PIVOT_Y:    pivot_in[1] = csr_wdata[COORD_WIDTH-1:0];
            ptap_pkg::CSR_PIVOT_Z:    pivot_in[2] = csr_wdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= ptap_pkg::ROW_TOP_RESET;
         row_ff[1] <= ptap_pkg::ROW_MIDDLE_RESET;
         row_ff[2] <= ptap_pkg::ROW_BOTTOM_RESET;
         for (int i = 0; i < 3; i++) begin
            pivot_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            row_ff[i]   <= row_in[i];
            pivot_ff[i] <= pivot_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rows[i]   = row_ff[i];
         pivots[i] = pivot_ff[i];
      end
   end

endmodule

// ----- src/ptap_datapath.sv -----
// Four-stage transform pipeline: offset, multiply, sum and round, add back and clip.
module ptap_datapath #(
   parameter int COORD_WIDTH = ptap_pkg::COORD_WIDTH_DEFAULT,
   parameter int COEF_WIDTH  = ptap_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [2:0][COORD_WIDTH-1:0]          in_point,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [2:0][COORD_WIDTH-1:0]          out_point,
   output logic                                 out_sat,
   input  logic [2:0][ptap_pkg::ROW_WIDTH-1:0]  rows,
   input  logic [2:0][COORD_WIDTH-1:0]          pivots
);

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = COEF_WIDTH + DW;
   localparam int SW  = PW + 2;
   localparam int QW  = SW - ptap_pkg::COEF_FRAC;
   localparam int VW  = ((QW > COORD_WIDTH) ? QW : COORD_WIDTH) + 1;
   localparam int TOP = VW - COORD_WIDTH + 1;

   localparam logic signed [SW-1:0] ROUND_HALF =
      {{(SW - ptap_pkg::COEF_FRAC){1'b0}}, 1'b1, {(ptap_pkg::COEF_FRAC - 1){1'b0}}};

   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic                        rdy1, rdy2, rdy3, rdy4;
   logic signed [DW-1:0]        diff_ff [3];
   logic signed [DW-1:0]        diff_in [3];
   logic signed [PW-1:0]        prod_ff [3][3];
   logic signed [PW-1:0]        prod_in [3][3];
   logic signed [SW-1:0]        sum_ff  [3];
   logic signed [SW-1:0]        sum_in  [3];
   logic [COORD_WIDTH-1:0]      res_ff  [3];
   logic [COORD_WIDTH-1:0]      res_in  [3];
   logic                        sat_ff, sat_in;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      logic signed [COEF_WIDTH-1:0] coef;
      logic [ptap_pkg::SLOT_BITS-1:0] slot;
      logic signed [VW-1:0] val;
      logic [TOP-1:0] top_bits;
      logic clip;
      sat_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         diff_in[c] = $signed({in_point[c][COORD_WIDTH-1], in_point[c]})
                    - $signed({pivots[c][COORD_WIDTH-1], pivots[c]});
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            slot = rows[r][(2 - c) * ptap_pkg::SLOT_BITS +: ptap_pkg::SLOT_BITS];
            coef = $signed(slot[COEF_WIDTH-1:0]);
            prod_in[r][c] = coef * diff_ff[c];
         end
         sum_in[r] = $signed({{2{prod_ff[r][0][PW-1]}}, prod_ff[r][0]})
                   + $signed({{2{prod_ff[r][1][PW-1]}}, prod_ff[r][1]})
                   + $signed({{2{prod_ff[r][2][PW-1]}}, prod_ff[r][2]})
                   + ROUND_HALF;
         val = $signed({{(VW - QW){sum_ff[r][SW-1]}}, sum_ff[r][SW-1:ptap_pkg::COEF_FRAC]})
             + $signed({{(VW - COORD_WIDTH){pivots[r][COORD_WIDTH-1]}}, pivots[r]});
         top_bits = val[VW-1:COORD_WIDTH-1];
         clip = !((&top_bits) || !(|top_bits));
         if (clip) begin
            res_in[r] = val[VW-1] ? {1'b1, {(COORD_WIDTH - 1){1'b0}}}
                                  : {1'b0, {(COORD_WIDTH - 1){1'b1}}};
         end else begin
            res_in[r] = val[COORD_WIDTH-1:0];
         end
         sat_in = sat_in | clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         for (int c = 0; c < 3; c++) diff_ff[c] <= diff_in[c];
      end
      if (rdy2 && v1_ff) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) prod_ff[r][c] <= prod_in[r][c];
         end
      end
      if (rdy3 && v2_ff) begin
         for (int r = 0; r < 3; r++) sum_ff[r] <= sum_in[r];
      end
      if (rdy4 && v3_ff) begin
         for (int r = 0; r < 3; r++) res_ff[r] <= res_in[r];
         sat_ff <= sat_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_sat   = sat_ff;
   always_comb begin
      for (int r = 0; r < 3; r++) out_point[r] = res_ff[r];
   end

endmodule

// ----- src/point_transform_about_pivot_top.sv -----
// Top level of the point transform about pivot block.
// Each beat on req carries one point p (signed Q16.8) and yields one beat on rsp holding
// M*(p - o) + o, with M the 3x3 Q4.12 matrix from the row registers and o the pivot.
// Row sums are exact, rounded half up to Q16.8 and clipped once; rsp_tuser flags a clip.
// One point is accepted every cycle while rsp is not stalled; a stalled rsp holds the
// last stage, and each earlier stage that holds a point behind a held stage waits too.
// Each point passes the offset, multiply, sum and clip registers in that order.
// Reset loads the identity and a zero pivot.
// Write the csr registers only while no point is in flight.
module point_transform_about_pivot_top #(
   parameter int COORD_WIDTH = ptap_pkg::COORD_WIDTH_DEFAULT,
   parameter int COEF_WIDTH  = ptap_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // in_x, in_y, in_z, zero fill
   input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_x, out_y, out_z, zero fill
   output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // saturated
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  ptap_pkg::csr_addr_type              csr_addr,
   input  logic [ptap_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int PTW = 3 * COORD_WIDTH;
   localparam int BW  = ((PTW + 7) / 8) * 8;

   logic [2:0][ptap_pkg::ROW_WIDTH-1:0] rows;
   logic [2:0][COORD_WIDTH-1:0]         pivots;
   logic [2:0][COORD_WIDTH-1:0]         in_point;
   logic [2:0][COORD_WIDTH-1:0]         out_point;

   assign in_point = req_tdata[PTW-1:0];

   generate
      if (BW > PTW) begin : g_pad
         assign rsp_tdata = {{(BW - PTW){1'b0}}, out_point};
      end else begin : g_nopad
         assign rsp_tdata = out_point;
      end
   endgenerate

   ptap_csr #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rows      (rows),
      .pivots    (pivots)
   );

   ptap_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_point  (in_point),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_point (out_point),
      .out_sat   (rsp_tuser),
      .rows      (rows),
      .pivots    (pivots)
   );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the point transform about pivot block: directed and random points.
localparam int CW     = ptap_pkg::COORD_WIDTH_DEFAULT;
localparam int DATA_W = ((3 * CW + 7) / 8) * 8;

typedef logic signed [CW-1:0] coord_type;

typedef struct packed {
   coord_type z;
   coord_type y;
   coord_type x;
} point_type;

typedef struct packed {
   logic      sat;
   point_type pt;
} result_type;

localparam coord_type COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
localparam coord_type COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

class transform_scoreboard;
   ptap_pkg::row_type rows [3];
   coord_type         pivot [3];
   result_type        due_results [$];
   int                mismatches;

   function new();
      rows[0]    = ptap_pkg::ROW_TOP_RESET;
      rows[1]    = ptap_pkg::ROW_MIDDLE_RESET;
      rows[2]    = ptap_pkg::ROW_BOTTOM_RESET;
      pivot[0]   = '0;
      pivot[1]   = '0;
      pivot[2]   = '0;
      mismatches = 0;
   endfunction

   function void write_reg(ptap_pkg::csr_addr_type idx, logic [ptap_pkg::CSR_DATA_WIDTH-1:0] value);
      case (idx)
         ptap_pkg::CSR_ROW_TOP:    rows[0]  = value[ptap_pkg::ROW_WIDTH-1:0];
         ptap_pkg::CSR_ROW_MIDDLE: rows[1]  = value[ptap_pkg::ROW_WIDTH-1:0];
         ptap_pkg::CSR_ROW_BOTTOM: rows[2]  = value[ptap_pkg::ROW_WIDTH-1:0];
         ptap_pkg::CSR_PIVOT_X:    pivot[0] = value[CW-1:0];
         ptap_pkg::CSR_PIVOT_Y:    pivot[1] = value[CW-1:0];
         ptap_pkg::CSR_PIVOT_Z:    pivot[2] = value[CW-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return due_results.size();
   endfunction

   // Compute M*(p - o) + o with exact sums, round half up, clip once.
   function void note_point(point_type p);
      longint             diff [3];
      longint             org [3];
      longint             acc;
      longint             val;
      longint             hi;
      longint             lo;
      coord_type          src [3];
      coord_type          dst [3];
      logic signed [15:0] coef;
      result_type         res;
      int                 r;
      int                 c;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      src[0] = p.x;
      src[1] = p.y;
      src[2] = p.z;
      res.sat = 1'b0;
      for (c = 0; c < 3; c++) begin
         org[c]  = pivot[c];
         diff[c] = longint'(src[c]) - org[c];
      end
      for (r = 0; r < 3; r++) begin
         acc = 0;
         for (c = 0; c < 3; c++) begin
            coef = rows[r][(2 - c) * ptap_pkg::SLOT_BITS +: 16];
            acc += coef * diff[c];
         end
         val = ((acc + (longint'(1) <<< (ptap_pkg::COEF_FRAC - 1))) >>> ptap_pkg::COEF_FRAC)
               + org[r];
         if (val > hi) begin
            val     = hi;
            res.sat = 1'b1;
         end else if (val < lo) begin
            val     = lo;
            res.sat = 1'b1;
         end
         dst[r] = coord_type'(val);
      end
      res.pt.x = dst[0];
      res.pt.y = dst[1];
      res.pt.z = dst[2];
      due_results.push_back(res);
   endfunction

   function void compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   function void check_result(point_type got, logic got_sat);
      result_type want;
      if (due_results.size() == 0) begin
         mismatches++;
         $error("rsp beat with no pending point: x %0d y %0d z %0d", got.x, got.y, got.z);
         return;
      end
      want = due_results.pop_front();
      compare_field("out_x", want.pt.x, got.x);
      compare_field("out_y", want.pt.y, got.y);
      compare_field("out_z", want.pt.z, got.z);
      compare_field("saturated", longint'(want.sat), longint'(got_sat));
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam ptap_pkg::csr_addr_type CSR_SPARE_A = 3'd6;
   localparam ptap_pkg::csr_addr_type CSR_SPARE_B = 3'd7;
   localparam int PIPE_LATENCY = 4;

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [DATA_W-1:0]                   req_tdata  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [DATA_W-1:0]                   rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   ptap_pkg::csr_addr_type              csr_addr   = '0;
   logic [ptap_pkg::CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   bit                  steady = 1'b0;
   transform_scoreboard sb;

   point_transform_about_pivot_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int pick_gap();
      int k;
      if (steady)
         return 0;
      k = $urandom_range(0, 99);
      if (k < 60)
         return 0;
      if (k < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic point_type make_point(coord_type x, coord_type y, coord_type z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      return p;
   endfunction

   function automatic coord_type random_coord();
      int k;
      k = $urandom_range(0, 19);
      if (k < 9)
         return coord_type'(int'($urandom_range(0, 32767)) - 16384);
      if (k < 17)
         return coord_type'($urandom);
      case ($urandom_range(0, 4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return coord_type'(0);
         3:       return coord_type'(-1);
         default: return coord_type'(1);
      endcase
   endfunction

   function automatic logic [15:0] random_coef();
      int k;
      k = $urandom_range(0, 9);
      if (k < 7)
         return 16'(int'($urandom_range(0, 16'h2000)) - 16'h1000);
      if (k < 8)
         return 16'($urandom);
      case ($urandom_range(0, 2))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic ptap_pkg::row_type random_row();
      if ($urandom_range(0, 4) == 0)
         return {16'($urandom), 32'($urandom)};
      return {random_coef(), random_coef(), random_coef()};
   endfunction

   function automatic logic [ptap_pkg::CSR_DATA_WIDTH-1:0] random_pivot();
      coord_type v;
      int        k;
      k = $urandom_range(0, 9);
      if (k < 3)
         v = '0;
      else if (k < 7)
         v = coord_type'(int'($urandom_range(0, 32767)) - 16384);
      else if (k < 9)
         v = coord_type'($urandom);
      else
         v = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      if ($urandom_range(0, 1))
         return {24'($urandom), v};
      return {24'd0, v};
   endfunction

   task automatic write_csr(ptap_pkg::csr_addr_type idx,
                            logic [ptap_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   task automatic set_settings(ptap_pkg::row_type top_row, ptap_pkg::row_type mid_row,
                               ptap_pkg::row_type bot_row,
                               logic [ptap_pkg::CSR_DATA_WIDTH-1:0] px,
                               logic [ptap_pkg::CSR_DATA_WIDTH-1:0] py,
                               logic [ptap_pkg::CSR_DATA_WIDTH-1:0] pz,
                               bit poke_spare);
      drain();
      write_csr(ptap_pkg::CSR_ROW_TOP, top_row);
      write_csr(ptap_pkg::CSR_ROW_MIDDLE, mid_row);
      write_csr(ptap_pkg::CSR_ROW_BOTTOM, bot_row);
      write_csr(ptap_pkg::CSR_PIVOT_X, px);
      write_csr(ptap_pkg::CSR_PIVOT_Y, py);
      write_csr(ptap_pkg::CSR_PIVOT_Z, pz);
      if (poke_spare) begin
         write_csr(CSR_SPARE_A, {16'($urandom), 32'($urandom)});
         write_csr(CSR_SPARE_B, {16'($urandom), 32'($urandom)});
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(point_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(p);
      do @(posedge clock); while (!req_tready);
      sb.note_point(p);
      @(negedge clock);
   endtask

   initial begin
      int hold;
      int len;
      hold = 0;
      forever begin
         @(negedge clock);
         if (steady) begin
            rsp_tready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            len = pick_gap();
            rsp_tready <= (len == 0);
            hold = (len == 0) ? $urandom_range(0, 6) : len - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(point_type'(rsp_tdata[3*CW-1:0]), rsp_tuser);
   end

   initial begin
      int phase;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity after reset
      send_point(make_point(0, 0, 0));
      send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
      send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN));
      send_point(make_point(1, -1, COORD_MIN));

      // half-scale diagonal: odd inputs land on rounding ties
      set_settings(48'h0800_0000_0000, 48'h0000_0800_0000, 48'h0000_0000_0800, 0, 0, 0, 0);
      send_point(make_point(1, -1, 3));
      send_point(make_point(-3, 5, -5));
      send_point(make_point(COORD_MIN, COORD_MAX, -7));

      // largest coefficients, extreme pivot: full-precision offset, clip high and low
      set_settings(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                   {24'd0, COORD_MIN}, {24'd0, COORD_MAX}, 0, 0);
      send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
      send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN));
      send_point(make_point(0, 0, 0));

      set_settings(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                   {24'd0, COORD_MAX}, {24'd0, COORD_MIN}, {24'd0, COORD_MIN}, 0);
      send_point(make_point(COORD_MIN, COORD_MAX, COORD_MAX));
      send_point(make_point(COORD_MAX, COORD_MIN, COORD_MIN));
      send_point(make_point(1, 2, 3));

      // zero matrix returns the pivot; spare indexes and upper pivot bits are dropped
      set_settings(48'h0, 48'h0, 48'h0, {24'hFFFFFF, 24'h123456}, {24'hA5A5A5, COORD_MIN},
                   {24'h5A5A5A, COORD_MAX}, 1);
      send_point(make_point(COORD_MAX, COORD_MIN, 77));
      send_point(make_point(-1, -1, -1));

      set_settings(ptap_pkg::ROW_TOP_RESET, ptap_pkg::ROW_MIDDLE_RESET,
                   ptap_pkg::ROW_BOTTOM_RESET, {24'hFFFFFF, COORD_MAX}, {24'd0, COORD_MIN},
                   {24'h000001, 24'h000100}, 0);
      send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX));
      send_point(make_point(COORD_MIN, COORD_MAX, COORD_MIN));
      send_point(make_point(0, 0, 0));

      for (phase = 0; phase < 10; phase++) begin
         set_settings(random_row(), random_row(), random_row(), random_pivot(),
                      random_pivot(), random_pivot(), $urandom_range(0, 3) == 0);
         steady = (phase % 4 == 3);
         repeat (105)
            send_point(make_point(random_coord(), random_coord(), random_coord()));
         steady = 1'b0;
      end

      drain();
      if (sb.mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

// ----- filelist.f -----
src/ptap_pkg.sv
src/ptap_csr.sv
src/ptap_datapath.sv
src/point_transform_about_pivot_top.sv
sim/testbench.sv
